@@ src/cstp_pkg.sv @@
package cstp_pkg;

  // field widths fixed by the event and readout formats
  localparam int FUNC_W  = 6;
  localparam int STAMP_W = 32;
  localparam int ACC_W   = 40;
  localparam int ERR_W   = 2;
  localparam int CNT_W   = 7;

  // parameter defaults
  localparam int MAX_FUNCS_DEF   = 64;
  localparam int STACK_DEPTH_DEF = 64;

  // depth of the command queue between front and back
  localparam int CMD_Q_DEPTH = 2;

  // reset value of the function count register
  localparam logic [CNT_W-1:0] NUM_FUNCS_RST = 7'd64;

  // event kinds
  localparam logic OP_START = 1'b0;
  localparam logic OP_END   = 1'b1;

  // sticky error codes
  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_BAD_ID    = 2'd3;

  // input transaction
  typedef struct packed {
    logic               op;
    logic [FUNC_W-1:0]  func_id;
    logic [STAMP_W-1:0] stamp;
    logic               final_event;
  } in_item_t;

  // readout transaction
  typedef struct packed {
    logic [FUNC_W-1:0]       out_func;
    logic signed [ACC_W-1:0] excl_time;
    logic [ERR_W-1:0]        err_code;
    logic                    is_last;
  } out_item_t;

  // what the back end does with a classified event
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_PUSH,
    CMD_POP
  } cmd_kind_t;

  // classified event passed from front to back
  typedef struct packed {
    cmd_kind_t          kind;
    logic [FUNC_W-1:0]  func_id;
    logic [STAMP_W-1:0] stamp;
    logic               final_event;
    logic [ERR_W-1:0]   err;
  } cmd_t;

  // one call stack entry
  typedef struct packed {
    logic [FUNC_W-1:0]  id;
    logic [STAMP_W-1:0] start;
  } frame_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_POP_TOP,
    BK_ADD,
    BK_SUB_RD,
    BK_SUB,
    BK_OUT_RD,
    BK_OUT_LD,
    BK_OUT_WAIT
  } back_state_t;

endpackage

@@ src/cstp_ram.sv @@
module cstp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/cstp_front.sv @@
module cstp_front
  import cstp_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  input  logic [CNT_W-1:0] n_funcs,
  input  logic             q_full,
  output logic             q_push,
  output cmd_t             q_cmd
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);

  logic [SPW-1:0]   sp_r, sp_nxt;
  logic [ERR_W-1:0] err_r, err_nxt;
  logic [ERR_W-1:0] code;
  logic             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  // classify the event against the stack depth the back end will see
  always_comb begin
    sp_nxt          = sp_r;
    code            = ERR_NONE;
    q_cmd.kind      = CMD_NONE;
    q_cmd.func_id   = in_data.func_id;
    q_cmd.stamp     = in_data.stamp;
    q_cmd.final_event = in_data.final_event;
    if (CNT_W'(in_data.func_id) >= n_funcs) begin
      code = ERR_BAD_ID;
    end else if (in_data.op == OP_START) begin
      if (sp_r == SPW'(STACK_DEPTH)) begin
        code = ERR_OVERFLOW;
      end else begin
        q_cmd.kind = CMD_PUSH;
        sp_nxt     = sp_r + SPW'(1);
      end
    end else begin
      if (sp_r == '0) begin
        code = ERR_UNDERFLOW;
      end else begin
        q_cmd.kind = CMD_POP;
        sp_nxt     = sp_r - SPW'(1);
      end
    end
    // first error sticks
    err_nxt   = (err_r == ERR_NONE) ? code : err_r;
    q_cmd.err = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r  <= '0;
      err_r <= ERR_NONE;
    end else if (accept) begin
      sp_r  <= sp_nxt;
      err_r <= err_nxt;
    end
  end

endmodule

@@ src/cstp_fifo.sv @@
module cstp_fifo
  import cstp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t head
);

  localparam int PW = (CMD_Q_DEPTH > 1) ? $clog2(CMD_Q_DEPTH) : 1;
  localparam int CW = $clog2(CMD_Q_DEPTH + 1);

  cmd_t           slot_r [CMD_Q_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign full      = (cnt_r == CW'(CMD_Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = slot_r[rd_ptr_r];

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(CMD_Q_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(CMD_Q_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ src/cstp_back.sv @@
module cstp_back
  import cstp_pkg::*;
#(
  parameter int MAX_FUNCS   = MAX_FUNCS_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_pop,
  input  cmd_t             q_cmd,
  input  logic [CNT_W-1:0] n_funcs,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  localparam int AW      = $clog2(MAX_FUNCS);
  localparam int SAW     = $clog2(STACK_DEPTH);
  localparam int SPW     = $clog2(STACK_DEPTH + 1);
  localparam int FRAME_W = $bits(frame_t);

  back_state_t          state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [SPW-1:0]       sp_r, sp_nxt, sp_dec;
  logic [ACC_W-1:0]     span_r, span_nxt;
  logic [AW-1:0]        top_r, top_nxt;
  logic [AW-1:0]        k_r, k_nxt;
  out_item_t            out_r, out_nxt;
  logic [MAX_FUNCS-1:0] acc_vld_r, acc_vld_nxt;
  logic                 rd_vld_r;
  logic                 k_last;

  // stack memory ports
  logic               stk_we;
  logic [SAW-1:0]     stk_waddr, stk_raddr;
  frame_t             stk_wdata, stk_q;
  logic [FRAME_W-1:0] stk_rdata;

  // accumulator memory ports
  logic             acc_we;
  logic [AW-1:0]    acc_waddr, acc_raddr;
  logic [ACC_W-1:0] acc_wdata, acc_rdata, acc_eff;

  cstp_ram #(.WIDTH(FRAME_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  cstp_ram #(.WIDTH(ACC_W), .DEPTH(MAX_FUNCS)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  assign stk_q     = frame_t'(stk_rdata);
  // an entry never written since the last readout reads as zero
  assign acc_eff   = rd_vld_r ? acc_rdata : '0;
  assign sp_dec    = sp_r - SPW'(1);
  assign k_last    = (CNT_W'(k_r) == n_funcs - CNT_W'(1));
  assign out_valid = (state_r == BK_OUT_WAIT);
  assign out_data  = out_r;

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    sp_nxt      = sp_r;
    span_nxt    = span_r;
    top_nxt     = top_r;
    k_nxt       = k_r;
    out_nxt     = out_r;
    acc_vld_nxt = acc_vld_r;
    q_pop       = 1'b0;
    stk_we      = 1'b0;
    stk_waddr   = sp_r[SAW-1:0];
    stk_wdata   = '{id: q_cmd.func_id, start: q_cmd.stamp};
    stk_raddr   = sp_dec[SAW-1:0];
    acc_we      = 1'b0;
    acc_waddr   = cmd_r.func_id[AW-1:0];
    acc_wdata   = acc_eff + span_r;
    acc_raddr   = cmd_r.func_id[AW-1:0];

    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          k_nxt   = '0;
          unique case (q_cmd.kind)
            CMD_PUSH: begin
              stk_we    = 1'b1;
              sp_nxt    = sp_r + SPW'(1);
              state_nxt = q_cmd.final_event ? BK_OUT_RD : BK_IDLE;
            end
            CMD_POP: begin
              // read the frame being popped
              sp_nxt    = sp_dec;
              state_nxt = BK_POP_TOP;
            end
            default: begin
              state_nxt = q_cmd.final_event ? BK_OUT_RD : BK_IDLE;
            end
          endcase
        end
      end
      BK_POP_TOP: begin
        // frame is here: form the span, read new top and the ending accumulator
        span_nxt  = ACC_W'(cmd_r.stamp) + ACC_W'(1) - ACC_W'(stk_q.start);
        state_nxt = BK_ADD;
      end
      BK_ADD: begin
        acc_we    = 1'b1;
        acc_waddr = cmd_r.func_id[AW-1:0];
        acc_wdata = acc_eff + span_r;
        top_nxt   = stk_q.id[AW-1:0];
        if ((sp_r != '0) && (CNT_W'(stk_q.id) < CNT_W'(MAX_FUNCS))) begin
          state_nxt = BK_SUB_RD;
        end else begin
          state_nxt = cmd_r.final_event ? BK_OUT_RD : BK_IDLE;
        end
      end
      BK_SUB_RD: begin
        acc_raddr = top_r;
        state_nxt = BK_SUB;
      end
      BK_SUB: begin
        acc_we    = 1'b1;
        acc_waddr = top_r;
        acc_wdata = acc_eff - span_r;
        state_nxt = cmd_r.final_event ? BK_OUT_RD : BK_IDLE;
      end
      BK_OUT_RD: begin
        acc_raddr = k_r;
        state_nxt = BK_OUT_LD;
      end
      BK_OUT_LD: begin
        out_nxt.out_func  = FUNC_W'(k_r);
        out_nxt.excl_time = acc_eff;
        out_nxt.err_code  = cmd_r.err;
        out_nxt.is_last   = k_last;
        state_nxt         = BK_OUT_WAIT;
      end
      BK_OUT_WAIT: begin
        if (out_ready) begin
          if (out_r.is_last) begin
            // readout done: the table reads as zero again
            acc_vld_nxt = '0;
            state_nxt   = BK_IDLE;
          end else begin
            k_nxt     = k_r + AW'(1);
            state_nxt = BK_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    if (acc_we) begin
      acc_vld_nxt[acc_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      sp_r      <= '0;
      acc_vld_r <= '0;
    end else begin
      state_r   <= state_nxt;
      sp_r      <= sp_nxt;
      acc_vld_r <= acc_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    span_r   <= span_nxt;
    top_r    <= top_nxt;
    k_r      <= k_nxt;
    out_r    <= out_nxt;
    rd_vld_r <= acc_vld_r[acc_raddr];
  end

endmodule

@@ src/call_stack_exclusive_time_profiler.sv @@
// Exclusive-time profiler for a decoded call trace. Start events push (id, stamp) onto an
// on-chip call stack; end events pop it, add end - start + 1 to the ending function's
// accumulator and subtract the same from the caller now on top. The input side takes one
// transaction per cycle into a two-entry command queue while it is not full, so it keeps
// taking events while the back end is busy, until the queue fills. In the back end a start
// or a rejected event is handled in BK_IDLE; an end event steps through POP_TOP, ADD, SUB_RD
// and SUB, set by the single read port of the stack RAM (popped frame, then new top) and of
// the accumulator RAM (two read-modify-writes); an end that empties the stack has no caller
// to charge and skips SUB_RD and SUB. After an event with final_event set, n_funcs entries
// are read out with out_ready high, then the table reads as zero again; the call stack and
// the sticky error code are kept. Reset clears the table at once through per-entry valid
// bits: no clearing pass. Write num_funcs only while no events are in flight.
module call_stack_exclusive_time_profiler
  import cstp_pkg::*;
#(
  parameter int MAX_FUNCS   = MAX_FUNCS_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  logic [CNT_W-1:0] num_funcs_r;
  logic [CNT_W-1:0] n_funcs;
  logic             q_full, q_push, q_pop, q_valid;
  cmd_t             q_in, q_head;

  // function count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_funcs_r <= NUM_FUNCS_RST;
    end else if (cfg_we) begin
      num_funcs_r <= cfg_wdata;
    end
  end

  // active count: zero acts as one, capped at the table size
  always_comb begin
    if (num_funcs_r == '0) begin
      n_funcs = CNT_W'(1);
    end else if (num_funcs_r > CNT_W'(MAX_FUNCS)) begin
      n_funcs = CNT_W'(MAX_FUNCS);
    end else begin
      n_funcs = num_funcs_r;
    end
  end

  cstp_front #(.STACK_DEPTH(STACK_DEPTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .n_funcs  (n_funcs),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_in)
  );

  cstp_fifo u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  cstp_back #(.MAX_FUNCS(MAX_FUNCS), .STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_head),
    .n_funcs   (n_funcs),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
